[src/pss_pkg.sv]
// Package: types, constants and helpers shared by the PWM slice scheduler.
`default_nettype none
package pss_pkg;

	localparam int CHANNELS = 8;
	localparam int SLOTS    = CHANNELS + 1;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int TICK_W   = 16;
	localparam int CHAN_W   = 3;
	localparam int CCNT_W   = 4;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic CMD_SET_DUTY = 1'b0;
	localparam logic CMD_EXPIRY   = 1'b1;

	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [CHANNELS-1:0] mask_t;
	typedef logic [TICK_W-1:0]   tick_t;

	typedef struct packed {
		logic              command;
		logic [CHAN_W-1:0] channel;
		tick_t             duty;
	} item_t;

	typedef struct packed {
		mask_t set_mask;
		mask_t clear_mask;
		tick_t next_delay;
		logic  rejected;
	} result_t;

	typedef struct packed {
		tick_t             period;
		logic              reverse;
		logic [CCNT_W-1:0] channel_count;
	} cfg_t;

	typedef enum logic [1:0] {
		REG_PERIOD,
		REG_REVERSE,
		REG_CHAN_COUNT
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP_RD,
		ST_EXP_OUT,
		ST_HEAD,
		ST_STRIP,
		ST_RM_INIT,
		ST_RM_CHK,
		ST_RM_LINK,
		ST_FIND_INIT,
		ST_FIND,
		ST_FREE,
		ST_LINK_NEW,
		ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_EXP_RD,
		OP_EXP_OUT,
		OP_HEAD,
		OP_STRIP,
		OP_RM_INIT,
		OP_RM_FREE,
		OP_RM_KEEP,
		OP_RM_LINK,
		OP_FIND_INIT,
		OP_FIND,
		OP_HIT,
		OP_FREE_INIT,
		OP_FREE_NEXT,
		OP_FREE_TAKE,
		OP_LINK_NEW
	} op_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_CUR,
		RD_CURRENT,
		RD_N
	} rd_sel_t;

	typedef struct packed {
		rd_sel_t rd;
		op_t     op;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic expiry;
		logic duty_zero;
		logic walk_end;
		logic slot_empty;
		logic find_more;
		logic find_hit;
		logic free_hit;
		logic n_last;
	} stat_t;

	// out-of-range slot numbers read as slot 0
	function automatic slot_t slot_ok(input slot_t s);
		slot_t r;
		r = (int'(s) < SLOTS) ? s : '0;
		return r;
	endfunction

endpackage
`default_nettype wire

[src/pwm_slice_scheduler.sv]
// Top level of the PWM slice scheduler: registers, controller and datapath.
//
// channel   | handshake                      | payload
// ----------+--------------------------------+-------------------------------
// item      | start, accepted when busy low  | item (command, channel, duty)
// result    | done, one cycle, no stall      | result (masks, delay, rejected)
// config    | APB write, pready tied high    | period, reverse, channel_count
//
// Expiry: two table reads after accept, then the strobe. Rejected set duty: the
// strobe follows accept. Accepted set duty: the single table read port is
// walked one slice per cycle over strip, prune and search passes, a freed slice
// adding a relink step, then one slot per cycle in the free-slot scan.
// Reset empties the table at once; no clearing pass. Results cannot be stalled.
`default_nettype none
module pwm_slice_scheduler (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  pss_pkg::item_t             item,
	output logic                       done,
	output pss_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pss_pkg::ADDR_W-1:0] paddr,
	input  logic [pss_pkg::DATA_W-1:0] pwdata,
	output logic [pss_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import pss_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	pss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pss_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.cfg    (cfg),
		.stat   (stat),
		.result (result)
	);

endmodule
`default_nettype wire

[src/pss_regs.sv]
// APB configuration registers: period, reverse, channel_count.
`default_nettype none
module pss_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pss_pkg::ADDR_W-1:0] paddr,
	input  logic [pss_pkg::DATA_W-1:0] pwdata,
	output logic [pss_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output pss_pkg::cfg_t              cfg
);
	import pss_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period        <= '1;
			cfg_q.reverse       <= 1'b0;
			cfg_q.channel_count <= CCNT_W'(CHANNELS);
		end else if (wr_en) begin
			unique case (idx)
				REG_PERIOD:     cfg_q.period        <= pwdata[TICK_W-1:0];
				REG_REVERSE:    cfg_q.reverse       <= pwdata[0];
				REG_CHAN_COUNT: cfg_q.channel_count <= pwdata[CCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PERIOD:     prdata = DATA_W'(cfg_q.period);
			REG_REVERSE:    prdata = DATA_W'(cfg_q.reverse);
			REG_CHAN_COUNT: prdata = DATA_W'(cfg_q.channel_count);
			default:        prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[src/pss_ctrl.sv]
// Controller state machine sequencing expiry and set-duty transactions.
`default_nettype none
module pss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  pss_pkg::stat_t stat,
	output pss_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);
	import pss_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (stat.expiry)
						state_d = ST_EXP_RD;
					else if (stat.reject)
						state_d = ST_DONE;
					else
						state_d = ST_HEAD;
				end
			end
			ST_EXP_RD:    state_d = ST_EXP_OUT;
			ST_EXP_OUT:   state_d = ST_DONE;
			ST_HEAD:      state_d = ST_STRIP;
			ST_STRIP: begin
				if (stat.walk_end)
					state_d = ST_RM_INIT;
			end
			ST_RM_INIT:   state_d = ST_RM_CHK;
			ST_RM_CHK: begin
				if (stat.walk_end)
					state_d = stat.duty_zero ? ST_DONE : ST_FIND_INIT;
				else if (stat.slot_empty)
					state_d = ST_RM_LINK;
			end
			ST_RM_LINK:   state_d = ST_RM_CHK;
			ST_FIND_INIT: state_d = ST_FIND;
			ST_FIND: begin
				if (!(!stat.walk_end && stat.find_more))
					state_d = stat.find_hit ? ST_DONE : ST_FREE;
			end
			ST_FREE: begin
				if (stat.free_hit)
					state_d = ST_LINK_NEW;
				else if (stat.n_last)
					state_d = ST_DONE;
			end
			ST_LINK_NEW:  state_d = ST_DONE;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.rd = RD_ZERO;
		cmd.op = OP_NONE;
		busy   = (state_q != ST_IDLE);
		done   = (state_q == ST_DONE);
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					cmd.op = OP_ACCEPT;
			end
			ST_EXP_RD: begin
				cmd.rd = RD_CURRENT;
				cmd.op = OP_EXP_RD;
			end
			ST_EXP_OUT: begin
				cmd.rd = RD_CUR;
				cmd.op = OP_EXP_OUT;
			end
			ST_HEAD: begin
				cmd.op = OP_HEAD;
			end
			ST_STRIP: begin
				cmd.rd = RD_CUR;
				if (!stat.walk_end)
					cmd.op = OP_STRIP;
			end
			ST_RM_INIT: begin
				cmd.op = OP_RM_INIT;
			end
			ST_RM_CHK: begin
				cmd.rd = RD_CUR;
				if (!stat.walk_end)
					cmd.op = stat.slot_empty ? OP_RM_FREE : OP_RM_KEEP;
			end
			ST_RM_LINK: begin
				cmd.op = OP_RM_LINK;
			end
			ST_FIND_INIT: begin
				cmd.op = OP_FIND_INIT;
			end
			ST_FIND: begin
				cmd.rd = RD_CUR;
				if (!stat.walk_end && stat.find_more)
					cmd.op = OP_FIND;
				else if (stat.find_hit)
					cmd.op = OP_HIT;
				else
					cmd.op = OP_FREE_INIT;
			end
			ST_FREE: begin
				cmd.rd = RD_N;
				if (stat.free_hit)
					cmd.op = OP_FREE_TAKE;
				else if (!stat.n_last)
					cmd.op = OP_FREE_NEXT;
			end
			ST_LINK_NEW: begin
				cmd.op = OP_LINK_NEW;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[src/pss_datapath.sv]
// Slice table, walk registers and result register of the scheduler.
`default_nettype none
module pss_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  pss_pkg::cmd_t    cmd,
	input  pss_pkg::item_t   item,
	input  pss_pkg::cfg_t    cfg,
	output pss_pkg::stat_t   stat,
	output pss_pkg::result_t result
);
	import pss_pkg::*;

	tick_t             tick_q [SLOTS];
	mask_t             set_q  [SLOTS];
	mask_t             clr_q  [SLOTS];
	slot_t             link_q [SLOTS];
	slot_t             current_q;
	slot_t             cur_q;
	slot_t             prev_q;
	logic [CNT_W-1:0]  n_q;
	mask_t             bit_q;
	tick_t             duty_q;
	tick_t             tcur_q;
	result_t           res_q;

	slot_t             rd_addr;
	tick_t             rd_tick;
	mask_t             rd_set;
	mask_t             rd_clr;
	slot_t             rd_next;
	logic [CCNT_W:0]   limit;
	logic              reject;
	tick_t             tnext;
	logic [CNT_W-1:0]  n_inc;

	always_comb begin
		unique case (cmd.rd)
			RD_ZERO:    rd_addr = '0;
			RD_CUR:     rd_addr = cur_q;
			RD_CURRENT: rd_addr = slot_ok(current_q);
			RD_N:       rd_addr = n_q[SLOT_W-1:0];
			default:    rd_addr = '0;
		endcase
	end

	assign rd_tick = tick_q[rd_addr];
	assign rd_set  = set_q[rd_addr];
	assign rd_clr  = clr_q[rd_addr];
	assign rd_next = slot_ok(link_q[rd_addr]);
	assign n_inc   = n_q + CNT_W'(1);

	assign limit  = ({1'b0, cfg.channel_count} < (CCNT_W + 1)'(CHANNELS))
		? {1'b0, cfg.channel_count} : (CCNT_W + 1)'(CHANNELS);
	assign reject = ((CCNT_W + 1)'(item.channel) >= limit) || (item.duty >= cfg.period);
	assign tnext  = (rd_tick == '0) ? cfg.period : rd_tick;

	assign stat.reject     = reject;
	assign stat.expiry     = (item.command == CMD_EXPIRY);
	assign stat.duty_zero  = (duty_q == '0);
	assign stat.walk_end   = (n_q >= CNT_W'(SLOTS)) || (cur_q == '0);
	assign stat.slot_empty = (rd_set == '0) && (rd_clr == '0);
	assign stat.find_more  = (rd_tick < duty_q);
	assign stat.find_hit   = (cur_q != '0) && (rd_tick == duty_q);
	assign stat.free_hit   = (rd_tick == '0);
	assign stat.n_last     = (n_q == CNT_W'(SLOTS - 1));

	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				tick_q[i] <= '0;
				set_q[i]  <= '0;
				clr_q[i]  <= '0;
				link_q[i] <= '0;
			end
			current_q <= '0;
			cur_q     <= '0;
			prev_q    <= '0;
			n_q       <= '0;
		end else begin
			case (cmd.op)
				OP_EXP_RD: begin
					cur_q <= rd_next;
				end
				OP_EXP_OUT: begin
					current_q <= cur_q;
				end
				OP_HEAD: begin
					if (duty_q == '0) begin
						set_q[0] <= set_q[0] & ~bit_q;
						clr_q[0] <= clr_q[0] | bit_q;
					end else begin
						clr_q[0] <= clr_q[0] & ~bit_q;
						set_q[0] <= set_q[0] | bit_q;
					end
					cur_q <= rd_next;
					n_q   <= '0;
				end
				OP_STRIP: begin
					set_q[cur_q] <= rd_set & ~bit_q;
					clr_q[cur_q] <= rd_clr & ~bit_q;
					cur_q        <= rd_next;
					n_q          <= n_inc;
				end
				OP_RM_INIT, OP_FIND_INIT: begin
					prev_q <= '0;
					cur_q  <= rd_next;
					n_q    <= '0;
				end
				OP_RM_FREE: begin
					tick_q[cur_q] <= '0;
					link_q[cur_q] <= '0;
					cur_q         <= rd_next;
					current_q     <= '0;
				end
				OP_RM_KEEP, OP_FIND: begin
					prev_q <= cur_q;
					cur_q  <= rd_next;
					n_q    <= n_inc;
				end
				OP_RM_LINK: begin
					link_q[prev_q] <= cur_q;
					n_q            <= n_inc;
				end
				OP_HIT: begin
					clr_q[cur_q] <= rd_clr | bit_q;
				end
				OP_FREE_INIT: begin
					n_q <= CNT_W'(1);
				end
				OP_FREE_NEXT: begin
					n_q <= n_inc;
				end
				OP_FREE_TAKE: begin
					tick_q[n_q[SLOT_W-1:0]] <= duty_q;
					set_q[n_q[SLOT_W-1:0]]  <= '0;
					clr_q[n_q[SLOT_W-1:0]]  <= bit_q;
					link_q[n_q[SLOT_W-1:0]] <= cur_q;
				end
				OP_LINK_NEW: begin
					link_q[prev_q] <= n_q[SLOT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				bit_q  <= mask_t'(1) << item.channel;
				duty_q <= item.duty;
				res_q  <= '{set_mask: '0, clear_mask: '0, next_delay: '0,
					rejected: (item.command == CMD_SET_DUTY) && reject};
			end
			OP_EXP_RD: begin
				tcur_q           <= rd_tick;
				res_q.set_mask   <= cfg.reverse ? rd_clr : rd_set;
				res_q.clear_mask <= cfg.reverse ? rd_set : rd_clr;
			end
			OP_EXP_OUT: begin
				res_q.next_delay <= tnext - tcur_q;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[src/pss_checker.sv]
// Port-level checker for the PWM slice scheduler, bound to the top level.
`default_nettype none
module pss_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input pss_pkg::result_t result
);
	import pss_pkg::*;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy transaction");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.rejected) |->
			(result.set_mask == '0 && result.clear_mask == '0 && result.next_delay == '0))
		else $error("rejected transaction carries nonzero payload");

endmodule

bind pwm_slice_scheduler pss_checker u_pss_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire
